FILE: hdl/srts_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
package srts_pkg;

    localparam int MAX_JOBS_DEF  = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int ARRIVAL_W    = 16;
    localparam int BURST_W      = 16;
    localparam int JOB_INDEX_W  = 4;
    localparam int COMPLETION_W = 21;
    localparam int TURNAROUND_W = 20;
    localparam int WAITING_W    = 20;

    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrive_at;
        logic [BURST_W-1:0]   service_units;
        logic                 last_job;
    } job_t;

    typedef struct packed {
        logic [JOB_INDEX_W-1:0]  job_index;
        logic [COMPLETION_W-1:0] finish_at;
        logic [TURNAROUND_W-1:0] turnaround_time;
        logic [WAITING_W-1:0]    wait_span;
        logic                    last_result;
    } result_t;

    // Commands broadcast from the controller to every cell
    typedef struct packed {
        logic load;
        logic update;
        logic finish;
        logic clear;
    } cell_ctl_t;

endpackage

FILE: hdl/shortest_remaining_time_scheduler.sv
// Preemptive shortest-remaining-time-first scheduler: job loader, cell chain and event controller.
// Jobs are taken one per cycle into a row of MAX_JOBS cells, in input order; a job beyond
// MAX_JOBS is dropped, but its last_job mark still starts the schedule. Scheduling is event
// driven rather than unit by unit: each event sends a selection record down the cell chain,
// one cell per cycle, which finds the ready job with least remaining time (ties to earlier
// arrival, then lower index) and the next pending arrival. Each event passes S_START, S_SCAN and
// S_DECIDE, then S_ADVANCE when a job runs; a completion adds S_FINISH and S_EMIT, which waits
// out any output stall. A set of n jobs needs at most about 2n events. No job is taken while
// a set is being scheduled, and the next set may load as soon as the final result sits in the
// output register.
module shortest_remaining_time_scheduler
    import srts_pkg::*;
#(
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_stall,
    input  job_t    job,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int CLK_W = TIME_BITS + CNT_W;

    typedef enum logic [6:0] {
        S_LOAD    = 7'b0000001,
        S_START   = 7'b0000010,
        S_SCAN    = 7'b0000100,
        S_DECIDE  = 7'b0001000,
        S_ADVANCE = 7'b0010000,
        S_FINISH  = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

    state_t               state_reg,     state_next;
    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    logic [CNT_W-1:0]     fin_reg,       fin_next;
    logic [CLK_W-1:0]     time_reg,      time_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg,       out_next;
    logic [TIME_BITS-1:0] run_reg,       run_next;
    logic [CLK_W-1:0]     tat_reg,       tat_next;
    logic                 w_found_reg,   w_found_next;
    logic [TIME_BITS-1:0] w_rem_reg,     w_rem_next;
    logic [TIME_BITS-1:0] w_arr_reg,     w_arr_next;
    logic [TIME_BITS-1:0] w_bur_reg,     w_bur_next;
    logic [IDX_W-1:0]     w_idx_reg,     w_idx_next;
    logic                 w_pend_reg,    w_pend_next;
    logic [TIME_BITS-1:0] w_next_reg,    w_next_next;

    cell_ctl_t            ctl;
    logic [IDX_W-1:0]     sel_idx;
    logic [TIME_BITS-1:0] upd_rem;
    logic                 kick;

    logic                 job_xfer;
    logic                 slot_free;
    logic [ARRIVAL_W+TIME_BITS-1:0] arr_wide;
    logic [BURST_W+TIME_BITS-1:0]   bur_wide;
    logic [CLK_W-1:0]     diff;
    logic [CLK_W-1:0]     rem_ext;
    logic                 cut;
    logic [TIME_BITS-1:0] run_pick;
    logic [TIME_BITS-1:0] rem_left;
    logic [CLK_W-1:0]     time_adv;
    logic [CLK_W-1:0]     tat_calc;
    logic [CLK_W-1:0]     wt_calc;
    logic [CNT_W-1:0]     fin_inc;
    logic                 set_done;
    logic [JOB_INDEX_W+IDX_W-1:0]  idx_wide;
    logic [COMPLETION_W+CLK_W-1:0] cmp_wide;
    logic [TURNAROUND_W+CLK_W-1:0] tat_wide;
    logic [WAITING_W+CLK_W-1:0]    wt_wide;

    // Chain links: entry 0 is the empty record injected by the controller
    logic                 ch_valid [0:MAX_JOBS];
    logic                 ch_found [0:MAX_JOBS];
    logic [TIME_BITS-1:0] ch_rem   [0:MAX_JOBS];
    logic [TIME_BITS-1:0] ch_arr   [0:MAX_JOBS];
    logic [TIME_BITS-1:0] ch_bur   [0:MAX_JOBS];
    logic [IDX_W-1:0]     ch_idx   [0:MAX_JOBS];
    logic                 ch_pend  [0:MAX_JOBS];
    logic [TIME_BITS-1:0] ch_next  [0:MAX_JOBS];

    assign ch_valid[0] = kick;
    assign ch_found[0] = 1'b0;
    assign ch_rem[0]   = '0;
    assign ch_arr[0]   = '0;
    assign ch_bur[0]   = '0;
    assign ch_idx[0]   = '0;
    assign ch_pend[0]  = 1'b0;
    assign ch_next[0]  = '0;

    // Build the row of job cells
    for (genvar k = 0; k < MAX_JOBS; k++)
    begin : g_cell
        srts_cell #(
            .TIME_BITS (TIME_BITS),
            .MAX_JOBS  (MAX_JOBS),
            .CELL_IDX  (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .sel_idx    (sel_idx),
            .load_arr   (arr_wide[TIME_BITS-1:0]),
            .load_bur   (bur_wide[TIME_BITS-1:0]),
            .upd_rem    (upd_rem),
            .cur_time   (time_reg),
            .cin_valid  (ch_valid[k]),
            .cin_found  (ch_found[k]),
            .cin_rem    (ch_rem[k]),
            .cin_arr    (ch_arr[k]),
            .cin_bur    (ch_bur[k]),
            .cin_idx    (ch_idx[k]),
            .cin_pend   (ch_pend[k]),
            .cin_next   (ch_next[k]),
            .cout_valid (ch_valid[k+1]),
            .cout_found (ch_found[k+1]),
            .cout_rem   (ch_rem[k+1]),
            .cout_arr   (ch_arr[k+1]),
            .cout_bur   (ch_bur[k+1]),
            .cout_idx   (ch_idx[k+1]),
            .cout_pend  (ch_pend[k+1]),
            .cout_next  (ch_next[k+1])
        );
    end

    // Handshake helpers
    assign job_stall = (state_reg != S_LOAD);
    assign job_xfer  = job_valid && !job_stall;
    assign slot_free = !out_valid_reg || !result_stall;

    // Fit input times to the time width
    assign arr_wide = {{TIME_BITS{1'b0}}, job.arrive_at};
    assign bur_wide = {{TIME_BITS{1'b0}}, job.service_units};

    // Run length: the winner runs until it ends or the next arrival comes in
    assign diff     = {{(CLK_W - TIME_BITS){1'b0}}, w_next_reg} - time_reg;
    assign rem_ext  = {{(CLK_W - TIME_BITS){1'b0}}, w_rem_reg};
    assign cut      = w_pend_reg && (diff < rem_ext);
    assign run_pick = cut ? diff[TIME_BITS-1:0] : w_rem_reg;
    assign rem_left = w_rem_reg - run_reg;
    assign time_adv = time_reg + {{(CLK_W - TIME_BITS){1'b0}}, run_reg};

    // Completion figures
    assign tat_calc = time_reg - {{(CLK_W - TIME_BITS){1'b0}}, w_arr_reg};
    assign wt_calc  = tat_reg - {{(CLK_W - TIME_BITS){1'b0}}, w_bur_reg};
    assign fin_inc  = fin_reg + CNT_W'(1);
    assign set_done = (fin_inc == cnt_reg);
    assign idx_wide = {{JOB_INDEX_W{1'b0}}, w_idx_reg};
    assign cmp_wide = {{COMPLETION_W{1'b0}}, time_reg};
    assign tat_wide = {{TURNAROUND_W{1'b0}}, tat_reg};
    assign wt_wide  = {{WAITING_W{1'b0}}, wt_calc};

    // Sequence loading, chain scans, time advance and result transfer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        run_next       = run_reg;
        tat_next       = tat_reg;
        w_found_next   = w_found_reg;
        w_rem_next     = w_rem_reg;
        w_arr_next     = w_arr_reg;
        w_bur_next     = w_bur_reg;
        w_idx_next     = w_idx_reg;
        w_pend_next    = w_pend_reg;
        w_next_next    = w_next_reg;
        ctl            = '0;
        sel_idx        = w_idx_reg;
        upd_rem        = rem_left;
        kick           = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                sel_idx = cnt_reg[IDX_W-1:0];
                if (job_xfer)
                begin
                    if (cnt_reg < CNT_W'(MAX_JOBS))
                    begin
                        ctl.load = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (job.last_job)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                kick       = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (ch_valid[MAX_JOBS])
                begin
                    w_found_next = ch_found[MAX_JOBS];
                    w_rem_next   = ch_rem[MAX_JOBS];
                    w_arr_next   = ch_arr[MAX_JOBS];
                    w_bur_next   = ch_bur[MAX_JOBS];
                    w_idx_next   = ch_idx[MAX_JOBS];
                    w_pend_next  = ch_pend[MAX_JOBS];
                    w_next_next  = ch_next[MAX_JOBS];
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (w_found_reg)
                begin
                    run_next   = run_pick;
                    state_next = S_ADVANCE;
                end
                else
                begin
                    // nothing ready: idle until the next arrival, or step the time by one when none is pending
                    if (w_pend_reg)
                    begin
                        time_next = {{(CLK_W - TIME_BITS){1'b0}}, w_next_reg};
                    end
                    else
                    begin
                        time_next = time_reg + CLK_W'(1);
                    end
                    state_next = S_START;
                end
            end
            S_ADVANCE:
            begin
                ctl.update = 1'b1;
                ctl.finish = (rem_left == '0);
                time_next  = time_adv;
                state_next = (rem_left == '0) ? S_FINISH : S_START;
            end
            S_FINISH:
            begin
                tat_next   = tat_calc;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.job_index       = idx_wide[JOB_INDEX_W-1:0];
                    out_next.finish_at       = cmp_wide[COMPLETION_W-1:0];
                    out_next.turnaround_time = tat_wide[TURNAROUND_W-1:0];
                    out_next.wait_span       = wt_wide[WAITING_W-1:0];
                    out_next.last_result     = set_done;
                    fin_next                 = fin_inc;
                    if (set_done)
                    begin
                        // drop the finished set and reopen for loading
                        ctl.clear  = 1'b1;
                        cnt_next   = '0;
                        fin_next   = '0;
                        time_next  = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            fin_reg       <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        run_reg     <= run_next;
        tat_reg     <= tat_next;
        w_found_reg <= w_found_next;
        w_rem_reg   <= w_rem_next;
        w_arr_reg   <= w_arr_next;
        w_bur_reg   <= w_bur_next;
        w_idx_reg   <= w_idx_next;
        w_pend_reg  <= w_pend_next;
        w_next_reg  <= w_next_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: hdl/srts_cell.sv
// One job cell: holds a job and folds it into the selection record passing down the chain.
module srts_cell
    import srts_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int CELL_IDX  = 0,
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
    localparam int CLK_W    = TIME_BITS + $clog2(MAX_JOBS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctl_t            ctl,
    input  logic [IDX_W-1:0]     sel_idx,
    input  logic [TIME_BITS-1:0] load_arr,
    input  logic [TIME_BITS-1:0] load_bur,
    input  logic [TIME_BITS-1:0] upd_rem,
    input  logic [CLK_W-1:0]     cur_time,
    input  logic                 cin_valid,
    input  logic                 cin_found,
    input  logic [TIME_BITS-1:0] cin_rem,
    input  logic [TIME_BITS-1:0] cin_arr,
    input  logic [TIME_BITS-1:0] cin_bur,
    input  logic [IDX_W-1:0]     cin_idx,
    input  logic                 cin_pend,
    input  logic [TIME_BITS-1:0] cin_next,
    output logic                 cout_valid,
    output logic                 cout_found,
    output logic [TIME_BITS-1:0] cout_rem,
    output logic [TIME_BITS-1:0] cout_arr,
    output logic [TIME_BITS-1:0] cout_bur,
    output logic [IDX_W-1:0]     cout_idx,
    output logic                 cout_pend,
    output logic [TIME_BITS-1:0] cout_next
);

    logic                 valid_reg;
    logic                 done_reg;
    logic [TIME_BITS-1:0] arr_reg;
    logic [TIME_BITS-1:0] bur_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic                 cv_reg;
    logic                 found_reg;
    logic [TIME_BITS-1:0] crem_reg;
    logic [TIME_BITS-1:0] carr_reg;
    logic [TIME_BITS-1:0] cbur_reg;
    logic [IDX_W-1:0]     cidx_reg;
    logic                 pend_reg;
    logic [TIME_BITS-1:0] next_reg;

    logic [CLK_W-1:0] arr_ext;
    logic             hit;
    logic             active;
    logic             ready;
    logic             pending;
    logic             take;
    logic             earlier;

    // Judge the own job against the record arriving from the left
    assign arr_ext = {{(CLK_W - TIME_BITS){1'b0}}, arr_reg};
    assign hit     = (sel_idx == IDX_W'(CELL_IDX));
    assign active  = valid_reg && !done_reg;
    assign ready   = active && (arr_ext <= cur_time);
    assign pending = active && !ready;
    assign take    = ready && (!cin_found || (rem_reg < cin_rem) ||
                               ((rem_reg == cin_rem) && (arr_reg < cin_arr)));
    assign earlier = pending && (!cin_pend || (arr_reg < cin_next));

    // Hold job flags; load, retire and clear on command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            cv_reg    <= 1'b0;
        end
        else
        begin
            cv_reg <= cin_valid;
            if (ctl.clear)
            begin
                valid_reg <= 1'b0;
                done_reg  <= 1'b0;
            end
            else if (ctl.load && hit)
            begin
                valid_reg <= 1'b1;
                done_reg  <= 1'b0;
            end
            else if (ctl.update && hit)
            begin
                done_reg <= ctl.finish;
            end
        end
    end

    // Hold job times and pass the record to the right
    always_ff @(posedge clk)
    begin
        if (ctl.load && hit)
        begin
            arr_reg <= load_arr;
            bur_reg <= load_bur;
            rem_reg <= load_bur;
        end
        else if (ctl.update && hit)
        begin
            rem_reg <= upd_rem;
        end
        found_reg <= cin_found || ready;
        crem_reg  <= take ? rem_reg : cin_rem;
        carr_reg  <= take ? arr_reg : cin_arr;
        cbur_reg  <= take ? bur_reg : cin_bur;
        cidx_reg  <= take ? IDX_W'(CELL_IDX) : cin_idx;
        pend_reg  <= cin_pend || pending;
        next_reg  <= earlier ? arr_reg : cin_next;
    end

    assign cout_valid = cv_reg;
    assign cout_found = found_reg;
    assign cout_rem   = crem_reg;
    assign cout_arr   = carr_reg;
    assign cout_bur   = cbur_reg;
    assign cout_idx   = cidx_reg;
    assign cout_pend  = pend_reg;
    assign cout_next  = next_reg;

endmodule
